/* design/bba_pkg.sv */
// Shared types, constants and helpers of the buddy block allocator.
// No dependencies; every other design file but bba_ram imports this package.
`default_nettype none
package bba_pkg;

    localparam int TOP      = 20;
    localparam int BOT      = 6;
    localparam int NLVL     = TOP - BOT + 1;
    localparam int GRAN     = 1 << (TOP - BOT);
    localparam int REGION   = 1 << TOP;
    localparam int OT_AW    = TOP - BOT;
    localparam int FM_WW    = 64;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TOO_BIG  = 2'd1;
    localparam logic [1:0] ST_NO_MEM   = 2'd2;
    localparam logic [1:0] ST_BAD_FREE = 2'd3;

    typedef enum logic [1:0] {
        K_ALLOC,
        K_TOO_BIG,
        K_FREE,
        K_BAD_FREE
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [4:0]  need;
        logic [19:0] faddr;
    } t_req;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_PICK,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SPLIT_RD,
        S_SPLIT_WR,
        S_GRANT,
        S_FREE_RD,
        S_FREE_CHK,
        S_MERGE_RD,
        S_MERGE_CHK,
        S_SET_RD,
        S_SET_WR,
        S_EMIT
    } t_state;

    // first free-map word of order k; each order starts on a word of its own
    function automatic int fm_off_int(input int k);
        int acc;
        acc = 0;
        for (int j = BOT; j < TOP; j++) begin
            if (j < k) acc += ((TOP - j) > 6) ? (1 << (TOP - j - 6)) : 1;
        end
        return acc;
    endfunction

    localparam int FM_WORDS = fm_off_int(TOP) + 1;
    localparam int FM_AW    = $clog2(FM_WORDS);

    function automatic logic [FM_AW-1:0] fm_off(input logic [4:0] k);
        return FM_AW'(fm_off_int(int'(k)));
    endfunction

endpackage
`default_nettype wire

/* design/bba_ram.sv */
// Generic simple dual-port RAM with registered read.
// No dependencies.
`default_nettype none
module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

/* design/bba_front.sv */
// Front end: takes input beats, rounds sizes to an order, screens addresses.
// Depends on bba_pkg.
`default_nettype none
module bba_front (
    input  wire logic          i_tvalid,
    output logic               o_tready,
    input  wire logic [47:0]   i_tdata,
    input  wire logic          i_tuser,
    input  wire logic          i_full,
    input  wire logic          i_busy,
    output logic               o_push,
    output bba_pkg::t_req      o_req
);
    import bba_pkg::*;

    logic [20:0] size;
    logic [20:0] sm1;
    logic [4:0]  msb;

    assign size = i_tdata[20:0];
    assign sm1  = size - 21'd1;

    always_comb begin
        msb = '0;
        for (int i = 0; i < 21; i++) begin
            if (sm1[i]) msb = 5'(i);
        end
    end

    always_comb begin
        o_req.faddr = i_tdata[40:21];
        o_req.need  = 5'(BOT);
        if (!i_tuser) begin
            if (size > 21'(REGION)) begin
                o_req.kind = K_TOO_BIG;
                o_req.need = '0;
            end else begin
                o_req.kind = K_ALLOC;
                if (size > (21'd1 << BOT)) o_req.need = msb + 5'd1;
            end
        end else begin
            o_req.kind = (o_req.faddr[BOT-1:0] != '0) ? K_BAD_FREE : K_FREE;
        end
    end

    assign o_tready = !i_full && !i_busy;
    assign o_push   = i_tvalid && o_tready;
endmodule
`default_nettype wire

/* design/bba_queue.sv */
// Two-entry request queue between front and back end.
// Depends on bba_pkg.
`default_nettype none
module bba_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  bba_pkg::t_req      i_req,
    output logic               o_full,
    input  wire logic          i_pop,
    output bba_pkg::t_req      o_req,
    output logic               o_empty
);
    import bba_pkg::*;

    t_req       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       do_push, do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_req   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wp <= !r_wp;
            if (do_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_req;
    end
endmodule
`default_nettype wire

/* design/bba_back.sv */
// Back end: sequencer that searches, splits and merges in the free map and
// keeps the order table and usage counters. Depends on bba_pkg and bba_ram.
`default_nettype none
module bba_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  bba_pkg::t_req      i_req,
    input  wire logic          i_empty,
    output logic               o_pop,
    output logic               o_busy,
    output logic               o_tvalid,
    input  wire logic          i_tready,
    output logic [87:0]        o_tdata
);
    import bba_pkg::*;

    t_state r_state, n_state;
    t_req   r_req, n_req;
    logic [4:0]       r_k, n_k;
    logic [19:0]      r_addr, n_addr;
    logic [FM_AW-1:0] r_word, n_word;
    logic [14:0]      r_cnt [NLVL];
    logic [14:0]      n_cnt [NLVL];
    logic [20:0]      r_used, n_used;
    logic [14:0]      r_live, n_live;
    logic [OT_AW-1:0] r_clr, n_clr;
    logic [1:0]       r_rst, n_rst;
    logic [19:0]      r_raddr, n_raddr;
    logic [4:0]       r_rord, n_rord;
    logic             r_ov, n_ov;
    logic [87:0]      r_od, n_od;

    logic             fm_we;
    logic [FM_AW-1:0] fm_waddr, fm_raddr;
    logic [FM_WW-1:0] fm_wdata, fm_q;
    logic             ot_we;
    logic [OT_AW-1:0] ot_waddr, ot_raddr;
    logic [4:0]       ot_wdata, ot_q;

    logic        pick_ok;
    logic [4:0]  pick_k;
    logic [5:0]  lb;
    logic [19:0] buddy, split_a;
    logic        free_ok;
    logic [19:0] omask;

    function automatic logic [3:0] lvl(input logic [4:0] k);
        return 4'(k - 5'(BOT));
    endfunction

    function automatic logic [FM_AW-1:0] node_word(input logic [4:0] k,
                                                  input logic [19:0] a);
        logic [13:0] idx;
        idx = 14'(a >> k);
        return fm_off(k) + FM_AW'(idx >> 6);
    endfunction

    function automatic logic [5:0] node_bit(input logic [4:0] k,
                                            input logic [19:0] a);
        logic [13:0] idx;
        idx = 14'(a >> k);
        return idx[5:0];
    endfunction

    bba_ram #(.WIDTH(FM_WW), .DEPTH(FM_WORDS)) u_fm (
        .i_clk(i_clk), .i_we(fm_we), .i_waddr(fm_waddr), .i_wdata(fm_wdata),
        .i_raddr(fm_raddr), .o_rdata(fm_q)
    );

    bba_ram #(.WIDTH(5), .DEPTH(GRAN)) u_ot (
        .i_clk(i_clk), .i_we(ot_we), .i_waddr(ot_waddr), .i_wdata(ot_wdata),
        .i_raddr(ot_raddr), .o_rdata(ot_q)
    );

    // lowest order at or above the needed one with a free block
    always_comb begin
        pick_ok = 1'b0;
        pick_k  = '0;
        for (int j = TOP; j >= BOT; j--) begin
            if (5'(j) >= r_req.need && r_cnt[j-BOT] != '0) begin
                pick_ok = 1'b1;
                pick_k  = 5'(j);
            end
        end
    end

    always_comb begin
        lb = '0;
        for (int i = FM_WW - 1; i >= 0; i--) begin
            if (fm_q[i]) lb = 6'(i);
        end
    end

    assign buddy   = r_addr ^ (20'd1 << r_k);
    assign split_a = r_addr + (20'd1 << r_k);
    assign omask   = ~(20'hFFFFF << ot_q);
    assign free_ok = (ot_q >= 5'(BOT)) && (ot_q <= 5'(TOP))
                   && ((r_req.faddr & omask) == '0);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:     if (r_clr == OT_AW'(GRAN - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (!i_empty) begin
                    unique case (i_req.kind)
                        K_ALLOC:               n_state = S_PICK;
                        K_FREE:                n_state = S_FREE_RD;
                        K_TOO_BIG, K_BAD_FREE: n_state = S_EMIT;
                        default:               n_state = S_EMIT;
                    endcase
                end
            end
            S_PICK:      n_state = pick_ok ? S_SCAN_RD : S_EMIT;
            S_SCAN_RD:   n_state = S_SCAN_CHK;
            S_SCAN_CHK: begin
                if (fm_q == '0)          n_state = S_SCAN_RD;
                else if (r_k > r_req.need) n_state = S_SPLIT_RD;
                else                     n_state = S_GRANT;
            end
            S_SPLIT_RD:  n_state = S_SPLIT_WR;
            S_SPLIT_WR:  n_state = (r_k > r_req.need) ? S_SPLIT_RD : S_GRANT;
            S_GRANT:     n_state = S_EMIT;
            S_FREE_RD:   n_state = S_FREE_CHK;
            S_FREE_CHK: begin
                if (!free_ok)               n_state = S_EMIT;
                else if (ot_q < 5'(TOP))    n_state = S_MERGE_RD;
                else                        n_state = S_SET_RD;
            end
            S_MERGE_RD:  n_state = S_MERGE_CHK;
            S_MERGE_CHK: begin
                if (fm_q[node_bit(r_k, buddy)] && (r_k + 5'd1 < 5'(TOP)))
                    n_state = S_MERGE_RD;
                else
                    n_state = S_SET_RD;
            end
            S_SET_RD:    n_state = S_SET_WR;
            S_SET_WR:    n_state = S_EMIT;
            S_EMIT:      if (!r_ov || i_tready) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_req  = r_req;
        n_k    = r_k;
        n_addr = r_addr;
        n_word = r_word;
        n_cnt  = r_cnt;
        n_used = r_used;
        n_live = r_live;
        n_clr  = r_clr;
        n_rst  = r_rst;
        n_raddr = r_raddr;
        n_rord = r_rord;
        n_ov   = (r_ov && i_tready) ? 1'b0 : r_ov;
        n_od   = r_od;
        o_pop  = 1'b0;
        fm_we    = 1'b0;
        fm_waddr = r_word;
        fm_wdata = fm_q;
        fm_raddr = r_word;
        ot_we    = 1'b0;
        ot_waddr = r_addr[TOP-1:BOT];
        ot_wdata = '0;
        ot_raddr = r_req.faddr[TOP-1:BOT];
        case (r_state)
            S_CLEAR: begin
                ot_we    = 1'b1;
                ot_waddr = r_clr;
                fm_we    = (32'(r_clr) < FM_WORDS);
                fm_waddr = r_clr[FM_AW-1:0];
                fm_wdata = (r_clr[FM_AW-1:0] == fm_off(5'(TOP))) ? FM_WW'(1) : '0;
                n_clr    = r_clr + 1'b1;
            end
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_req   = i_req;
                    n_raddr = (i_req.kind == K_BAD_FREE) ? i_req.faddr : '0;
                    n_rord  = '0;
                    n_rst   = (i_req.kind == K_BAD_FREE) ? ST_BAD_FREE : ST_TOO_BIG;
                end
            end
            S_PICK: begin
                n_k    = pick_k;
                n_word = fm_off(pick_k);
                n_rst  = ST_NO_MEM;
                n_raddr = '0;
                n_rord = r_req.need;
            end
            S_SCAN_CHK: begin
                if (fm_q == '0) begin
                    n_word = r_word + 1'b1;
                end else begin
                    fm_we    = 1'b1;
                    fm_wdata = fm_q & ~(FM_WW'(1) << lb);
                    n_cnt[lvl(r_k)] = r_cnt[lvl(r_k)] - 15'd1;
                    n_addr = 20'({14'(r_word - fm_off(r_k)), lb}) << r_k;
                end
            end
            S_SPLIT_RD: begin
                n_k      = r_k - 5'd1;
                fm_raddr = node_word(r_k - 5'd1, r_addr + (20'd1 << (r_k - 5'd1)));
            end
            S_SPLIT_WR: begin
                fm_we    = 1'b1;
                fm_waddr = node_word(r_k, split_a);
                fm_wdata = fm_q | (FM_WW'(1) << node_bit(r_k, split_a));
                n_cnt[lvl(r_k)] = r_cnt[lvl(r_k)] + 15'd1;
            end
            S_GRANT: begin
                ot_we    = 1'b1;
                ot_wdata = r_req.need;
                n_used   = r_used + (21'd1 << r_req.need);
                n_live   = r_live + 15'd1;
                n_rst    = ST_OK;
                n_raddr  = r_addr;
                n_rord   = r_req.need;
            end
            S_FREE_CHK: begin
                n_raddr = r_req.faddr;
                if (!free_ok) begin
                    n_rst  = ST_BAD_FREE;
                    n_rord = '0;
                end else begin
                    ot_we    = 1'b1;
                    ot_waddr = r_req.faddr[TOP-1:BOT];
                    n_used   = r_used - (21'd1 << ot_q);
                    n_live   = r_live - 15'd1;
                    n_k      = ot_q;
                    n_addr   = r_req.faddr;
                    n_rst    = ST_OK;
                    n_rord   = ot_q;
                end
            end
            S_MERGE_RD: fm_raddr = node_word(r_k, buddy);
            S_MERGE_CHK: begin
                if (fm_q[node_bit(r_k, buddy)]) begin
                    fm_we    = 1'b1;
                    fm_waddr = node_word(r_k, buddy);
                    fm_wdata = fm_q & ~(FM_WW'(1) << node_bit(r_k, buddy));
                    n_cnt[lvl(r_k)] = r_cnt[lvl(r_k)] - 15'd1;
                    n_addr = r_addr & ~(20'd1 << r_k);
                    n_k    = r_k + 5'd1;
                end
            end
            S_SET_RD: fm_raddr = node_word(r_k, r_addr);
            S_SET_WR: begin
                fm_we    = 1'b1;
                fm_waddr = node_word(r_k, r_addr);
                fm_wdata = fm_q | (FM_WW'(1) << node_bit(r_k, r_addr));
                n_cnt[lvl(r_k)] = r_cnt[lvl(r_k)] + 15'd1;
            end
            S_EMIT: begin
                if (!r_ov || i_tready) begin
                    n_ov = 1'b1;
                    n_od = {4'd0, r_live, 21'(REGION) - r_used, r_used,
                            r_rord, r_raddr, r_rst};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_ov    <= 1'b0;
            r_used  <= '0;
            r_live  <= '0;
            for (int i = 0; i < NLVL; i++)
                r_cnt[i] <= (i == NLVL - 1) ? 15'd1 : 15'd0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_ov    <= n_ov;
            r_used  <= n_used;
            r_live  <= n_live;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req   <= n_req;
        r_k     <= n_k;
        r_addr  <= n_addr;
        r_word  <= n_word;
        r_rst   <= n_rst;
        r_raddr <= n_raddr;
        r_rord  <= n_rord;
        r_od    <= n_od;
    end

    assign o_busy   = (r_state == S_CLEAR);
    assign o_tvalid = r_ov;
    assign o_tdata  = r_od;

    a_empty_no_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_live == '0) |-> (r_used == '0))
        else $error("bytes held with no live block");
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= 21'(REGION))
        else $error("used bytes exceed region");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == S_IDLE))
        else $error("queue popped while busy");
    a_top_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt[NLVL-1] <= 15'd1)
        else $error("more than one whole-region block free");
endmodule
`default_nettype wire

/* design/buddy_block_allocator.sv */
// Top level of the buddy block allocator: front end, request queue, back end.
// Depends on bba_pkg, bba_front, bba_queue, bba_back (and bba_ram below it).
//
// Binary buddy allocator over a 1 MiB region with 64-byte granules. Each input
// beat is an allocate (tuser 0) or free (tuser 1) and yields exactly one
// result beat. After reset the block runs a clearing pass over all 16384
// order-table entries and the free map, during which s_axis_tready stays low.
// Every request leaves the queue in the idle step and loads the result register
// in the emit step. On top of that an allocate picks an order, reads and checks
// 64-bit free-map words at that order (up to 256 words at the smallest order),
// reads and writes the map per split and records the grant. A free with an
// unaligned address needs nothing more; any other free reads and checks the
// order table and, if valid, reads and checks the map per merge and reads and
// writes it to mark the result free. The free map has a single RAM port.
// A 2-entry queue lets new beats enter while the back end works; the result
// register holds a finished beat while m_axis_tready is low, and the back end
// waits in its emit step until that register frees up.
`default_nettype none
module buddy_block_allocator (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // [20:0] request_size, [40:21] free_address, rest zero
    input  wire logic [47:0]  i_s_axis_tdata,
    // [0] action
    input  wire logic         i_s_axis_tuser,
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // [1:0] status, [21:2] block_address, [26:22] block_order,
    // [47:27] used_bytes, [68:48] free_bytes, [83:69] live_blocks, rest zero
    output logic [87:0]       o_m_axis_tdata
);
    import bba_pkg::*;

    t_req push_req, pop_req;
    logic push, full, pop, empty, busy;

    bba_front u_front (
        .i_tvalid(i_s_axis_tvalid), .o_tready(o_s_axis_tready),
        .i_tdata(i_s_axis_tdata), .i_tuser(i_s_axis_tuser),
        .i_full(full), .i_busy(busy), .o_push(push), .o_req(push_req)
    );

    bba_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_req(push_req),
        .o_full(full), .i_pop(pop), .o_req(pop_req), .o_empty(empty)
    );

    bba_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(pop_req), .i_empty(empty),
        .o_pop(pop), .o_busy(busy), .o_tvalid(o_m_axis_tvalid),
        .i_tready(i_m_axis_tready), .o_tdata(o_m_axis_tdata)
    );
endmodule
`default_nettype wire

/* bench/tb.sv */
// Self-checking bench for buddy_block_allocator: stream stimulus, own allocator model.
// Depends on bba_pkg (constants and status codes) and the design sources under design/.
`timescale 1ns / 1ps
module tb;
    import bba_pkg::*;

    localparam int CYCLE_LIMIT = 5000000;
    localparam int NODES       = 2 * GRAN - 1;

    typedef struct packed {
        logic [1:0]  status;
        logic [19:0] addr;
        logic [4:0]  order;
        logic [20:0] used;
        logic [20:0] freeb;
        logic [14:0] live;
    } t_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_valid;
    logic [47:0] s_data;
    logic        s_user;
    logic        m_ready;
    wire         s_ready;
    wire         m_valid;
    wire  [87:0] m_data;

    buddy_block_allocator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    // model state: one free bit per tree node, order per granule, counters
    bit         node_free [NODES];
    logic [4:0] base_order [GRAN];
    int         used_cnt;
    int         live_cnt;

    t_res grant_q [$];       // pending results, oldest first
    int   held_addrs [$];    // bases of blocks the model holds allocated
    int   mismatches;
    int   cycles;
    int   hold_req;          // long receiver hold-off, in cycles
    bit   no_idle;           // sender gaps and receiver stalls off
    int   status_seen [4];

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        s_user  = 1'b0;
        m_ready = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", grant_q.size());
            $display("simulation failed");
            $finish;
        end
    end

    function automatic int node_idx(int ord, int addr);
        return ((1 << (TOP - ord)) - 1) + (addr >> ord);
    endfunction

    function automatic void model_reset();
        foreach (node_free[i]) node_free[i] = 1'b0;
        foreach (base_order[i]) base_order[i] = '0;
        node_free[0] = 1'b1;
        used_cnt = 0;
        live_cnt = 0;
    endfunction

    // one step of the allocator: updates model state, returns the result beat
    function automatic t_res buddy_step(bit is_free, int size, int faddr);
        t_res r;
        int   need, k, cnt, base, addr, ord, buddy, bn;
        bit   found;
        r = '0;
        if (!is_free) begin
            if (size > REGION) begin
                r.status = ST_TOO_BIG;
            end else begin
                need = BOT;
                found = 1'b0;
                addr = 0;
                while (need < TOP && (1 << need) < size) need++;
                for (k = need; k <= TOP; k++) begin
                    cnt  = 1 << (TOP - k);
                    base = cnt - 1;
                    for (int i = 0; i < cnt; i++) begin
                        if (node_free[base + i]) begin
                            found = 1'b1;
                            addr = i << k;
                            node_free[base + i] = 1'b0;
                            break;
                        end
                    end
                    if (found) break;
                end
                r.order = 5'(need);
                if (!found) begin
                    r.status = ST_NO_MEM;
                end else begin
                    // split down, upper halves go free
                    while (k > need) begin
                        k--;
                        node_free[node_idx(k, addr + (1 << k))] = 1'b1;
                    end
                    base_order[addr >> BOT] = 5'(need);
                    used_cnt += 1 << need;
                    live_cnt++;
                    r.status = ST_OK;
                    r.addr = 20'(addr);
                end
            end
        end else begin
            ord = 0;
            if ((faddr & ((1 << BOT) - 1)) == 0) ord = base_order[faddr >> BOT];
            r.addr = 20'(faddr);
            if (ord < BOT || ord > TOP || (faddr & ((1 << ord) - 1)) != 0) begin
                r.status = ST_BAD_FREE;
            end else begin
                base_order[faddr >> BOT] = '0;
                used_cnt -= 1 << ord;
                live_cnt--;
                r.status = ST_OK;
                r.order = 5'(ord);
                addr = faddr;
                // merge upward while the buddy is free
                while (ord < TOP) begin
                    buddy = addr ^ (1 << ord);
                    bn = node_idx(ord, buddy);
                    if (!node_free[bn]) break;
                    node_free[bn] = 1'b0;
                    if (buddy < addr) addr = buddy;
                    ord++;
                end
                node_free[node_idx(ord, addr)] = 1'b1;
            end
        end
        r.used  = 21'(used_cnt);
        r.freeb = 21'(REGION - used_cnt);
        r.live  = 15'(live_cnt);
        return r;
    endfunction

    // offer one request beat; predict once it is taken
    task automatic send_req(bit is_free, int size, int faddr);
        int   gap;
        t_res r;
        // fields as the block sees them on the bus
        size  = size & 32'h1FFFFF;
        faddr = faddr & 32'hFFFFF;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_user  <= is_free;
        s_data  <= {7'b0, 20'(faddr), 21'(size)};
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        r = buddy_step(is_free, size, faddr);
        grant_q.push_back(r);
        status_seen[r.status]++;
        if (r.status == ST_OK) begin
            if (!is_free) begin
                held_addrs.push_back(int'(r.addr));
            end else begin
                foreach (held_addrs[i])
                    if (held_addrs[i] == faddr) begin
                        held_addrs.delete(i);
                        break;
                    end
            end
        end
    endtask

    task automatic drain();
        if (s_valid) s_valid <= 1'b0;
        while (grant_q.size() > 0) @(posedge i_clk);
    endtask

    task automatic free_held(int pick);
        send_req(1'b1, $urandom(), held_addrs[pick]);
    endtask

    // result side: random stall, optional long hold, field compare
    initial begin
        int   stall;
        t_res got, want;
        @(posedge i_rst_n);
        forever begin
            if (hold_req > 0) begin
                m_ready <= 1'b0;
                repeat (hold_req) @(posedge i_clk);
                hold_req = 0;
            end
            stall = no_idle ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_ready <= 1'b1;
            @(posedge i_clk);
            while (!m_valid) @(posedge i_clk);
            got = '{status: m_data[1:0], addr: m_data[21:2], order: m_data[26:22],
                    used: m_data[47:27], freeb: m_data[68:48], live: m_data[83:69]};
            if (grant_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %h", m_data);
            end else begin
                want = grant_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp st=%0d a=%h o=%0d u=%0d f=%0d l=%0d",
                                  " / got st=%0d a=%h o=%0d u=%0d f=%0d l=%0d"},
                                 want.status, want.addr, want.order, want.used,
                                 want.freeb, want.live, got.status, got.addr,
                                 got.order, got.used, got.freeb, got.live);
                end
            end
        end
    end

    // extremes and every special case from an empty region
    task automatic test_corner_cases();
        send_req(1'b0, 0, 0);           // zero size gets a smallest block
        send_req(1'b0, 1, 0);
        send_req(1'b0, 64, 0);
        send_req(1'b0, 65, 0);
        send_req(1'b0, REGION + 1, 0);  // too large
        send_req(1'b0, 21'h1FFFFF, 20'hFFFFF);
        send_req(1'b0, REGION, 0);      // whole region while partly used
        send_req(1'b1, 0, 32);          // unaligned
        send_req(1'b1, 0, 320);         // no block starts there
        send_req(1'b1, 0, 0);
        send_req(1'b1, 0, 0);           // double free
        send_req(1'b1, 0, 64);
        send_req(1'b1, 0, 128);
        send_req(1'b1, 0, 256);         // merges back to whole region
        send_req(1'b0, REGION, 0);
        send_req(1'b0, 0, 0);           // out of memory at bottom order
        send_req(1'b1, 0, 20'hFFFC0);
        send_req(1'b1, 0, 0);
        send_req(1'b0, REGION / 2, 0);
        send_req(1'b0, REGION / 2 + 1, 0);
        send_req(1'b1, 21'h1FFFFF, 20'hFFFFF);
        send_req(1'b1, 0, 0);
        drain();
    endtask

    // mostly legal alloc/free traffic on small blocks, some noise
    task automatic test_random_mix(int n);
        int r, o, sz;
        for (int i = 0; i < n; i++) begin
            if (i % 150 == 0) no_idle = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (held_addrs.size() > 250 && r < 50) r = 60;
            if (r < 50) begin
                o = ($urandom_range(0, 19) == 0) ? $urandom_range(BOT, TOP)
                                                 : $urandom_range(BOT, 11);
                sz = $urandom_range(0, 3) == 0 ? (1 << o)
                                               : $urandom_range(0, 1 << o);
                send_req(1'b0, sz, $urandom());
            end else if (r < 85 && held_addrs.size() > 0) begin
                free_held($urandom_range(0, held_addrs.size() - 1));
            end else if (r < 92) begin
                send_req(1'b0, $urandom_range(0, 21'h1FFFFF), $urandom());
            end else if (r < 96 || held_addrs.size() == 0) begin
                send_req(1'b1, $urandom(), $urandom_range(0, 20'hFFFFF));
            end else begin
                send_req(1'b1, $urandom(),
                         held_addrs[$urandom_range(0, held_addrs.size() - 1)]
                         + (1 << $urandom_range(0, 10)));
            end
        end
        no_idle = 1'b0;
        drain();
    endtask

    // large grants until the region runs out, then release everything
    task automatic test_exhaust_and_release();
        for (int i = 0; i < 24; i++)
            send_req(1'b0, $urandom_range(REGION / 16, REGION / 4), 0);
        for (int i = 0; i < 20; i++)
            send_req(1'b0, $urandom_range(0, 4096), 0);
        while (held_addrs.size() > 0)
            free_held($urandom_range(0, held_addrs.size() - 1));
        drain();
    endtask

    // receiver stalls long while requests keep coming: input must back up
    task automatic test_backpressure();
        hold_req = 600;
        for (int i = 0; i < 40; i++) begin
            if (i % 3 != 2 || held_addrs.size() == 0)
                send_req(1'b0, $urandom_range(0, 512), 0);
            else
                free_held(0);
        end
        drain();
        while (held_addrs.size() > 0) free_held(0);
        drain();
    endtask

    initial begin
        cycles     = 0;
        mismatches = 0;
        hold_req   = 0;
        no_idle    = 1'b0;
        model_reset();
        @(posedge i_rst_n);
        test_corner_cases();
        test_backpressure();
        test_random_mix(1250);
        test_exhaust_and_release();
        repeat (64) @(posedge i_clk);
        $display("covered: %0d ok, %0d too large, %0d out of memory, %0d bad free beats",
                 status_seen[ST_OK], status_seen[ST_TOO_BIG], status_seen[ST_NO_MEM],
                 status_seen[ST_BAD_FREE]);
        $display("%0d mismatches, %0d results left over, %0d cycles",
                 mismatches, grant_q.size(), cycles);
        if (mismatches == 0 && grant_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* buddy_block_allocator.f */
design/bba_pkg.sv
design/bba_ram.sv
design/bba_front.sv
design/bba_queue.sv
design/bba_back.sv
design/buddy_block_allocator.sv
bench/tb.sv
